// ===== src/flt_pkg.sv =====
// Shared types and constants for the file lock table.
`default_nettype none

package flt_pkg;

    // Fixed field widths of the stream payloads
    localparam int unsigned OP_W      = 2;
    localparam int unsigned FILE_W    = 4;
    localparam int unsigned PID_W     = 8;
    localparam int unsigned IO_W      = 16;
    localparam int unsigned OUTCOME_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // Register reset values (ms)
    localparam logic [IO_W-1:0] READ_IO_RESET  = 16'd4000;
    localparam logic [IO_W-1:0] WRITE_IO_RESET = 16'd6000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_IO  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_IO = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_GRANTED  = 3'd0,
        OC_QUEUED   = 3'd1,
        OC_IDLE     = 3'd2,
        OC_HANDED   = 3'd3,
        OC_IGNORED  = 3'd4,
        OC_REJECTED = 3'd5
    } outcome_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch request, read file row
        logic fetch;    // read head waiter
        logic commit;   // write state, load result register
    } flt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hand_needed;  // release with waiters pending
        logic out_free;     // result register can take a new result
    } flt_sts_t;

endpackage

`default_nettype wire

// ===== src/flt_ctrl.sv =====
// Sequencing state machine for the file lock table.
`default_nettype none

module flt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire flt_pkg::flt_sts_t sts,
    output flt_pkg::flt_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HANDOFF
    } state_t;

    state_t state_reg;

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.fetch  = 1'b1;
                cmd.commit = !sts.hand_needed && sts.out_free;
            end
            ST_HANDOFF:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (sts.hand_needed)
                    begin
                        state_reg <= ST_HANDOFF;
                    end
                    else if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_HANDOFF:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/flt_datapath.sv =====
// File table, waiter queues, config registers and result register.
`default_nettype none

module flt_datapath #(
    parameter int unsigned NUM_FILES   = 16,
    parameter int unsigned QUEUE_DEPTH = 8,
    parameter int unsigned PID_WIDTH   = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire flt_pkg::flt_cmd_t                   cmd,
    output flt_pkg::flt_sts_t                        sts,
    input  wire logic [flt_pkg::OP_W-1:0]            in_op,
    input  wire logic [flt_pkg::FILE_W-1:0]          in_file,
    input  wire logic [flt_pkg::PID_W-1:0]           in_pid,
    input  wire logic                                cfg_valid,
    input  wire logic [flt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [flt_pkg::IO_W-1:0]            cfg_data,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [flt_pkg::OUTCOME_W-1:0]            out_outcome,
    output logic [flt_pkg::PID_W-1:0]                out_gpid,
    output logic [flt_pkg::IO_W-1:0]                 out_io,
    output logic [flt_pkg::PID_W-1:0]                out_cur
);

    localparam int unsigned FW       = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
    localparam int unsigned QW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW       = CW + 1;
    localparam int unsigned WQ_DEPTH = NUM_FILES * QUEUE_DEPTH;
    localparam int unsigned AW       = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
    localparam int unsigned EXT_W    = 9;
    localparam int unsigned PID_EXT  = 16;
    localparam int unsigned IO_W     = flt_pkg::IO_W;
    localparam logic [EXT_W-1:0] NF_LIMIT = EXT_W'(NUM_FILES);

    typedef struct packed {
        logic [PID_WIDTH-1:0] owner;
        logic [QW-1:0]        head;
        logic [CW-1:0]        count;
    } row_t;

    typedef struct packed {
        logic [IO_W-1:0]      io;
        logic [PID_WIDTH-1:0] pid;
    } waiter_t;

    // Storage
    row_t                 row_mem [NUM_FILES];
    waiter_t              wq_mem  [WQ_DEPTH];
    logic [NUM_FILES-1:0] owner_valid_reg;

    // Config registers
    logic [IO_W-1:0] read_io_reg;
    logic [IO_W-1:0] write_io_reg;

    // Latched request
    flt_pkg::op_t         op_reg;
    logic [FW-1:0]        file_reg;
    logic                 in_range_reg;
    logic [PID_WIDTH-1:0] pid_reg;
    logic [IO_W-1:0]      io_reg;
    logic                 held_reg;
    row_t                 row_reg;
    waiter_t              wq_rd_reg;

    // Result register
    logic                           out_valid_reg;
    logic [flt_pkg::OUTCOME_W-1:0]  out_outcome_reg;
    logic [flt_pkg::PID_W-1:0]      out_gpid_reg;
    logic [IO_W-1:0]                out_io_reg;
    logic [flt_pkg::PID_W-1:0]      out_cur_reg;

    // Accept-side decode
    logic [EXT_W-1:0]     acc_ext;
    logic [FW-1:0]        acc_idx;
    logic                 acc_in_range;
    logic [PID_EXT-1:0]   acc_pid_ext;

    // Decision
    logic                 is_req;
    logic                 same_owner;
    logic                 full;
    logic [SW-1:0]        tail_sum;
    logic [SW-1:0]        tail_wrap;
    logic [QW-1:0]        tail_slot;
    logic [SW-1:0]        head_inc;
    logic [QW-1:0]        next_head;
    logic [AW-1:0]        wq_base;
    logic [AW-1:0]        wq_wr_addr;
    logic [AW-1:0]        wq_rd_addr;
    logic                 hand_needed;

    flt_pkg::outcome_t    res_outcome;
    logic [PID_WIDTH-1:0] res_gpid;
    logic [IO_W-1:0]      res_io;
    logic [PID_WIDTH-1:0] res_cur;
    logic [PID_EXT-1:0]   res_gpid_ext;
    logic [PID_EXT-1:0]   res_cur_ext;
    row_t                 row_next;
    logic                 row_we;
    logic                 wq_we;
    logic                 valid_set;
    logic                 valid_clr;

    assign acc_ext      = EXT_W'(in_file);
    assign acc_idx      = acc_ext[FW-1:0];
    assign acc_in_range = acc_ext < NF_LIMIT;
    assign acc_pid_ext  = PID_EXT'(in_pid);

    assign is_req     = (op_reg == flt_pkg::OP_READ) || (op_reg == flt_pkg::OP_WRITE);
    assign same_owner = row_reg.owner == pid_reg;
    assign full       = row_reg.count == CW'(QUEUE_DEPTH);

    // FIFO slot arithmetic; head + count stays below twice the depth
    assign tail_sum   = SW'(row_reg.head) + SW'(row_reg.count);
    assign tail_wrap  = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH)
                                                        : tail_sum;
    assign tail_slot  = tail_wrap[QW-1:0];
    assign head_inc   = SW'(row_reg.head) + SW'(1);
    assign next_head  = (head_inc == SW'(QUEUE_DEPTH)) ? '0 : head_inc[QW-1:0];

    assign wq_base    = AW'(file_reg) * AW'(QUEUE_DEPTH);
    assign wq_wr_addr = wq_base + AW'(tail_slot);
    assign wq_rd_addr = wq_base + AW'(row_reg.head);

    assign hand_needed = (op_reg == flt_pkg::OP_RELEASE) && in_range_reg && held_reg
                         && (row_reg.count != '0);

    always_comb
    begin
        res_outcome = flt_pkg::OC_IGNORED;
        res_gpid    = '0;
        res_io      = '0;
        res_cur     = '0;
        row_next    = row_reg;
        row_we      = 1'b0;
        wq_we       = 1'b0;
        valid_set   = 1'b0;
        valid_clr   = 1'b0;
        if (is_req)
        begin
            if (!in_range_reg)
            begin
                res_outcome = flt_pkg::OC_REJECTED;
            end
            else if (!held_reg || same_owner)
            begin
                res_outcome    = flt_pkg::OC_GRANTED;
                res_gpid       = pid_reg;
                res_io         = io_reg;
                row_next.owner = pid_reg;
                if (!held_reg)
                begin
                    // row of a free file may be stale or never written
                    row_next.head  = '0;
                    row_next.count = '0;
                end
                row_we    = 1'b1;
                valid_set = 1'b1;
            end
            else if (full)
            begin
                res_outcome = flt_pkg::OC_REJECTED;
                res_cur     = row_reg.owner;
            end
            else
            begin
                res_outcome    = flt_pkg::OC_QUEUED;
                res_cur        = row_reg.owner;
                row_next.count = row_reg.count + CW'(1);
                row_we         = 1'b1;
                wq_we          = 1'b1;
            end
        end
        else if ((op_reg == flt_pkg::OP_RELEASE) && in_range_reg && held_reg)
        begin
            if (hand_needed)
            begin
                res_outcome    = flt_pkg::OC_HANDED;
                res_gpid       = wq_rd_reg.pid;
                res_io         = wq_rd_reg.io;
                row_next.owner = wq_rd_reg.pid;
                row_next.head  = next_head;
                row_next.count = row_reg.count - CW'(1);
                row_we         = 1'b1;
            end
            else
            begin
                res_outcome = flt_pkg::OC_IDLE;
                valid_clr   = 1'b1;
            end
        end
    end

    assign res_gpid_ext = PID_EXT'(res_gpid);
    assign res_cur_ext  = PID_EXT'(res_cur);

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_io_reg  <= flt_pkg::READ_IO_RESET;
            write_io_reg <= flt_pkg::WRITE_IO_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                flt_pkg::CFG_READ_IO:  read_io_reg  <= cfg_data;
                flt_pkg::CFG_WRITE_IO: write_io_reg <= cfg_data;
                default:               read_io_reg  <= read_io_reg;
            endcase
        end
    end

    // Request latch, file row read and file row write
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= flt_pkg::op_t'(in_op);
            file_reg     <= acc_idx;
            in_range_reg <= acc_in_range;
            pid_reg      <= acc_pid_ext[PID_WIDTH-1:0];
            io_reg       <= (flt_pkg::op_t'(in_op) == flt_pkg::OP_WRITE) ? write_io_reg
                                                                          : read_io_reg;
            held_reg     <= owner_valid_reg[acc_idx];
            row_reg      <= row_mem[acc_idx];
        end
        if (cmd.commit && row_we)
        begin
            row_mem[file_reg] <= row_next;
        end
    end

    // Waiter store: one write and one read port
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            wq_rd_reg <= wq_mem[wq_rd_addr];
        end
        if (cmd.commit && wq_we)
        begin
            wq_mem[wq_wr_addr] <= '{io: io_reg, pid: pid_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (valid_set)
            begin
                owner_valid_reg[file_reg] <= 1'b1;
            end
            else if (valid_clr)
            begin
                owner_valid_reg[file_reg] <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_outcome_reg <= res_outcome;
            out_gpid_reg    <= res_gpid_ext[flt_pkg::PID_W-1:0];
            out_io_reg      <= res_io;
            out_cur_reg     <= res_cur_ext[flt_pkg::PID_W-1:0];
        end
    end

    assign sts.hand_needed = hand_needed;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_outcome = out_outcome_reg;
    assign out_gpid    = out_gpid_reg;
    assign out_io      = out_io_reg;
    assign out_cur     = out_cur_reg;

endmodule

`default_nettype wire

// ===== src/file_lock_table_with_fifo_waiters.sv =====
// Top level of the file lock table with FIFO wait queues.
//
//  Channel | Direction | Handshake                      | Payload
//  --------+-----------+--------------------------------+---------------------------------
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | tuser op, tdata file + pid
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | tuser outcome, tdata pid/io/owner
//  cfg     | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data (io times)
//
// One request at a time. A transfer on s_axis is followed by a file-row lookup
// state; grants, queue pushes, rejects, idle releases and ignores commit there.
// A release handed to a waiter reads the waiter store (registered read port) in
// the lookup state and commits from the handoff state that follows.
// The result sits in an output register; the next request is taken while it
// waits. A new result stalls at commit until that register is free.
// Reset (rst_n, async) frees every file and empties every queue at once; no
// clearing pass. cfg_ready is always high.
`default_nettype none

module file_lock_table_with_fifo_waiters #(
    parameter int unsigned NUM_FILES   = 16,
    parameter int unsigned QUEUE_DEPTH = 8,
    parameter int unsigned PID_WIDTH   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [3:0] file_index, [11:4] requester_pid, [15:12] 0
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] granted_pid, [23:8] io_time,
                                             // [31:24] current_owner
    output logic [2:0]       m_axis_tuser,   // [2:0] outcome
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,      // 0 read_io_time, 1 write_io_time
    input  wire logic [15:0] cfg_data
);

    flt_pkg::flt_cmd_t cmd;
    flt_pkg::flt_sts_t sts;

    logic [flt_pkg::PID_W-1:0] out_gpid;
    logic [flt_pkg::IO_W-1:0]  out_io;
    logic [flt_pkg::PID_W-1:0] out_cur;

    flt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    flt_datapath #(
        .NUM_FILES   (NUM_FILES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_WIDTH   (PID_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_op       (s_axis_tuser),
        .in_file     (s_axis_tdata[3:0]),
        .in_pid      (s_axis_tdata[11:4]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_outcome (m_axis_tuser),
        .out_gpid    (out_gpid),
        .out_io      (out_io),
        .out_cur     (out_cur)
    );

    // Config writes are never back-pressured
    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {out_cur, out_io, out_gpid};

endmodule

`default_nettype wire

// ===== src/flt_checker.sv =====
// Port-level checks for the file lock table, bound to the top level.
`default_nettype none

module flt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // Held result does not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One request in flight: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a request is in flight");

    // No new owner reported unless granted or handed
    a_no_owner_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == flt_pkg::OC_QUEUED
            || m_axis_tuser == flt_pkg::OC_IDLE || m_axis_tuser == flt_pkg::OC_IGNORED
            || m_axis_tuser == flt_pkg::OC_REJECTED)
        |-> m_axis_tdata[23:0] == 24'd0)
        else $error("granted pid or io time set on a non-grant result");

    // Current owner only reported for queued or rejected requests
    a_cur_owner: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == flt_pkg::OC_GRANTED
            || m_axis_tuser == flt_pkg::OC_HANDED || m_axis_tuser == flt_pkg::OC_IDLE
            || m_axis_tuser == flt_pkg::OC_IGNORED)
        |-> m_axis_tdata[31:24] == 8'd0)
        else $error("current owner set on a grant or release result");

endmodule

bind file_lock_table_with_fifo_waiters flt_checker u_flt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the file lock table with FIFO wait queues.
module tb_top;

    import flt_pkg::*;

    localparam int unsigned NFILES = 16;
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned PIDW   = 8;

    // One result of the lock table, as the m_axis payload carries it
    typedef struct packed {
        outcome_t        outcome;
        logic [PID_W-1:0] gpid;
        logic [IO_W-1:0]  io;
        logic [PID_W-1:0] owner;
    } lock_result_t;

    // Directed stimulus: pin set means the row carries its own result
    typedef struct packed {
        op_t               op;
        logic [FILE_W-1:0] fidx;
        logic [PID_W-1:0]  pid;
        logic              pin;
        lock_result_t      want;
    } dir_row_t;

    // Reset register values are in force for these rows. File 15 gets an owner,
    // then eight waiters (one pid twice) fill its queue, and the ninth bounces.
    localparam int unsigned N_DIRECTED = 23;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_RELEASE, 4'd0,  8'h00, 1'b1, '{OC_IGNORED,  8'h00, 16'd0,    8'h00}},
        '{OP_RSVD,    4'd15, 8'hFF, 1'b1, '{OC_IGNORED,  8'h00, 16'd0,    8'h00}},
        '{OP_READ,    4'd0,  8'h00, 1'b1, '{OC_GRANTED,  8'h00, 16'd4000, 8'h00}},
        '{OP_WRITE,   4'd0,  8'h00, 1'b1, '{OC_GRANTED,  8'h00, 16'd6000, 8'h00}},
        '{OP_WRITE,   4'd15, 8'hFF, 1'b1, '{OC_GRANTED,  8'hFF, 16'd6000, 8'h00}},
        '{OP_READ,    4'd15, 8'h01, 1'b0, '0},
        '{OP_WRITE,   4'd15, 8'h80, 1'b0, '0},
        '{OP_READ,    4'd15, 8'h55, 1'b0, '0},
        '{OP_WRITE,   4'd15, 8'hAA, 1'b0, '0},
        '{OP_READ,    4'd15, 8'h01, 1'b0, '0},
        '{OP_READ,    4'd15, 8'h0F, 1'b0, '0},
        '{OP_WRITE,   4'd15, 8'hF0, 1'b0, '0},
        '{OP_READ,    4'd15, 8'hFE, 1'b0, '0},
        '{OP_WRITE,   4'd15, 8'h7F, 1'b1, '{OC_REJECTED, 8'h00, 16'd0,    8'hFF}},
        '{OP_READ,    4'd15, 8'hFF, 1'b1, '{OC_GRANTED,  8'hFF, 16'd4000, 8'h00}},
        '{OP_RELEASE, 4'd15, 8'h00, 1'b0, '0},
        '{OP_RELEASE, 4'd15, 8'h00, 1'b0, '0},
        '{OP_READ,    4'd15, 8'h33, 1'b0, '0},
        '{OP_RSVD,    4'd0,  8'h00, 1'b1, '{OC_IGNORED,  8'h00, 16'd0,    8'h00}},
        '{OP_RELEASE, 4'd0,  8'hA5, 1'b1, '{OC_IDLE,     8'h00, 16'd0,    8'h00}},
        '{OP_RELEASE, 4'd0,  8'h00, 1'b1, '{OC_IGNORED,  8'h00, 16'd0,    8'h00}},
        '{OP_READ,    4'd7,  8'h5A, 1'b0, '0},
        '{OP_RELEASE, 4'd7,  8'h00, 1'b1, '{OC_IDLE,     8'h00, 16'd0,    8'h00}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    // Directed rows tag the item on the bus with their own result; changed
    // by NBA together with the payload so the monitor sees a matching pair.
    logic         item_pinned = 1'b0;
    lock_result_t item_want = '0;

    // Idle rates in percent per cycle, and the long receiver hold-off
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold = 1'b0;

    // Shadow lock table
    logic [IO_W-1:0]  rd_io = READ_IO_RESET;
    logic [IO_W-1:0]  wr_io = WRITE_IO_RESET;
    logic             held       [NFILES];
    logic [PID_W-1:0] lock_owner [NFILES];
    logic [PID_W-1:0] wait_pid   [NFILES][QDEPTH];
    logic [IO_W-1:0]  wait_io    [NFILES][QDEPTH];
    logic [2:0]       wait_head  [NFILES];
    int unsigned      wait_cnt   [NFILES];

    lock_result_t pending_results[$];

    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned outcome_seen [8];

    // Small pid pool so owners re-request and contention builds up
    localparam logic [7:0] PID_POOL [6] = '{8'h00, 8'h01, 8'h3C, 8'h7E, 8'h81, 8'hFF};

    file_lock_table_with_fifo_waiters #(
        .NUM_FILES   (NFILES),
        .QUEUE_DEPTH (QDEPTH),
        .PID_WIDTH   (PIDW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [3:0] file_index, [11:4] requester_pid
        .s_axis_tuser  (s_axis_tuser),   // [1:0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] gpid, [23:8] io_time, [31:24] owner
        .m_axis_tuser  (m_axis_tuser),   // [2:0] outcome
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Generous time limit; reaching it reports a mismatch and ends the run
    initial
    begin
        #400000;
        $display("file_lock_table_with_fifo_waiters: mismatch");
        $finish;
    end

    initial
    begin
        for (int f = 0; f < NFILES; f++)
        begin
            held[f] = 1'b0;
            lock_owner[f] = '0;
            wait_head[f] = '0;
            wait_cnt[f] = 0;
        end
        foreach (outcome_seen[k])
            outcome_seen[k] = 0;
    end

    // Lock table behavior for one request or release; updates the shadow state
    function automatic lock_result_t predict_lock(op_t op, logic [FILE_W-1:0] fidx,
                                                  logic [PID_W-1:0] pid);
        lock_result_t r;
        logic [2:0]   slot;
        logic [IO_W-1:0] io;
        r = '0;
        r.outcome = OC_IGNORED;
        io = (op == OP_READ) ? rd_io : wr_io;
        if (op == OP_READ || op == OP_WRITE)
        begin
            if (!held[fidx] || lock_owner[fidx] == pid)
            begin
                // free file, or the owner asking again
                held[fidx] = 1'b1;
                lock_owner[fidx] = pid;
                r.outcome = OC_GRANTED;
                r.gpid = pid;
                r.io = io;
            end
            else if (wait_cnt[fidx] >= QDEPTH)
            begin
                r.outcome = OC_REJECTED;
                r.owner = lock_owner[fidx];
            end
            else
            begin
                slot = wait_head[fidx] + 3'(wait_cnt[fidx]);
                wait_pid[fidx][slot] = pid;
                wait_io[fidx][slot] = io;
                wait_cnt[fidx]++;
                r.outcome = OC_QUEUED;
                r.owner = lock_owner[fidx];
            end
        end
        else if (op == OP_RELEASE && held[fidx])
        begin
            if (wait_cnt[fidx] != 0)
            begin
                // hand over to the oldest waiter with its stored io time
                slot = wait_head[fidx];
                wait_head[fidx] = slot + 3'd1;
                wait_cnt[fidx]--;
                lock_owner[fidx] = wait_pid[fidx][slot];
                r.outcome = OC_HANDED;
                r.gpid = wait_pid[fidx][slot];
                r.io = wait_io[fidx][slot];
            end
            else
            begin
                held[fidx] = 1'b0;
                r.outcome = OC_IDLE;
            end
        end
        return r;
    endfunction

    task automatic check_field(string what, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    // Bus monitor: checks results, predicts on accepted requests, tracks registers.
    // Everything here is sampled at the edge, before any NBA of that edge lands.
    always @(posedge clk)
    begin
        lock_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                outcome_seen[m_axis_tuser]++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with none pending, expected nothing, got "
                             , $time, "outcome %0d data %h", m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("outcome", want.outcome, m_axis_tuser);
                    check_field("granted_pid", want.gpid, m_axis_tdata[7:0]);
                    check_field("io_time", want.io, m_axis_tdata[23:8]);
                    check_field("current_owner", want.owner, m_axis_tdata[31:24]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_lock(op_t'(s_axis_tuser), s_axis_tdata[3:0],
                                    s_axis_tdata[11:4]);
                if (item_pinned)
                    want = item_want;
                pending_results.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_READ_IO)
                    rd_io = cfg_data;
                else
                    wr_io = cfg_data;
            end
        end
    end

    // Result side backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one request and hold it until the transfer; maybe idle afterwards.
    // Valid stays high between back-to-back items.
    task automatic send_item(op_t op, logic [FILE_W-1:0] fidx, logic [PID_W-1:0] pid,
                             logic pin, lock_result_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'd0, pid, fidx};
        item_pinned   <= pin;
        item_want     <= want;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Stop offering and wait for every pending result, plus the block's latency.
    // One edge first so the monitor has queued the last accepted item.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both io time registers back to back; block must be idle
    task automatic program_io(logic [IO_W-1:0] rd_val, logic [IO_W-1:0] wr_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_READ_IO;
        cfg_data  <= rd_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_WRITE_IO;
        cfg_data  <= wr_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly contended traffic on a few files, some spread over all of them.
    // A full stop every 200 items lets queues settle with nothing in flight.
    task automatic send_random(int unsigned count, int unsigned release_pct);
        op_t              op;
        logic [FILE_W-1:0] fidx;
        logic [PID_W-1:0]  pid;
        int unsigned       r;
        for (int unsigned i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < release_pct)
                op = OP_RELEASE;
            else if (r < release_pct + 3)
                op = OP_RSVD;
            else
                op = $urandom_range(1) ? OP_WRITE : OP_READ;
            fidx = ($urandom_range(99) < 75) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            pid = ($urandom_range(99) < 60) ? PID_POOL[$urandom_range(5)]
                                            : 8'($urandom_range(255));
            send_item(op, fidx, pid, 1'b0, '0);
            if (i % 200 == 199)
                drain();
        end
    endtask

    // Long receiver stall, counted here while the sender keeps pushing
    task automatic hold_receiver(int unsigned cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset register values
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].fidx, DIRECTED[i].pid,
                      DIRECTED[i].pin, DIRECTED[i].want);
        drain();

        // Sender rarely idle, receiver mostly stalled
        program_io(16'd0, 16'hFFFF);
        tx_idle_pct <= 10;
        rx_idle_pct <= 79;
        send_random(600, 35);
        drain();

        // Roles swapped
        program_io(16'hFFFF, 16'd0);
        tx_idle_pct <= 79;
        rx_idle_pct <= 10;
        send_random(600, 25);
        drain();

        // Full rate; first a long hold-off so the block backs up into its input
        program_io(16'($urandom), 16'($urandom));
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        fork
            hold_receiver(300);
            send_random(150, 30);
        join
        send_random(500, 45);
        drain();
        repeat (20) @(posedge clk);

        $display("%0d requests and %0d results over reset, extreme and random io times,",
                 items_sent, results_seen);
        $display("granted %0d queued %0d idle %0d handed %0d ignored %0d rejected %0d",
                 outcome_seen[OC_GRANTED], outcome_seen[OC_QUEUED], outcome_seen[OC_IDLE],
                 outcome_seen[OC_HANDED], outcome_seen[OC_IGNORED],
                 outcome_seen[OC_REJECTED]);
        if (errors == 0)
            $display("file_lock_table_with_fifo_waiters: match");
        else
            $display("file_lock_table_with_fifo_waiters: mismatch");
        $finish;
    end

endmodule
